// ===== rtl/core/r_type_alu_executor_defines.svh =====
// Assertion macros used by the checker file.
`ifndef R_TYPE_ALU_EXECUTOR_DEFINES_SVH
`define R_TYPE_ALU_EXECUTOR_DEFINES_SVH

// Checked only while out of reset.
`define RTAEX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define RTAEX_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/rtaex_pkg.sv =====
`timescale 1ns / 1ps

package rtaex_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int DATA_W    = 32;
   localparam int SHAMT_W   = 5;
   localparam int OPC_W     = 6;
   localparam int FUNCT_W   = 6;

   localparam logic [OPC_W-1:0] OPC_SPECIAL = 6'h00;

   localparam logic [FUNCT_W-1:0] FN_SLL = 6'h00;
   localparam logic [FUNCT_W-1:0] FN_SRL = 6'h02;
   localparam logic [FUNCT_W-1:0] FN_SRA = 6'h03;
   localparam logic [FUNCT_W-1:0] FN_ADD = 6'h20;
   localparam logic [FUNCT_W-1:0] FN_SUB = 6'h22;
   localparam logic [FUNCT_W-1:0] FN_AND = 6'h24;
   localparam logic [FUNCT_W-1:0] FN_OR  = 6'h25;
   localparam logic [FUNCT_W-1:0] FN_XOR = 6'h26;
   localparam logic [FUNCT_W-1:0] FN_NOR = 6'h27;
   localparam logic [FUNCT_W-1:0] FN_SLT = 6'h2a;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] addr;
      logic [DATA_W-1:0]    data;
   } rf_write_type;

endpackage

// ===== rtl/core/rtaex_if.sv =====
`timescale 1ns / 1ps

interface rtaex_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [rtaex_pkg::DATA_W-1:0]    instruction_word;
   logic [rtaex_pkg::REG_IDX_W-1:0] load_index;
   logic [rtaex_pkg::DATA_W-1:0]    load_value;

   modport source (output valid, mode, instruction_word, load_index, load_value,
                   input ready);
   modport sink (input valid, mode, instruction_word, load_index, load_value,
                 output ready);
endinterface

interface rtaex_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rtaex_pkg::REG_IDX_W-1:0] dest_index;
   logic [rtaex_pkg::DATA_W-1:0]    dest_value;
   logic                            wrote;
   logic                            status;

   modport source (output valid, dest_index, dest_value, wrote, status, input ready);
   modport sink (input valid, dest_index, dest_value, wrote, status, output ready);
endinterface

// ===== rtl/core/r_type_alu_executor.sv =====
`timescale 1ns / 1ps
// A transaction accepted into the s1 registers is loaded into the rsp register
// once rsp is free, and rsp hands it off from there.
// Throughput: one transaction per cycle while rsp is not stalled; the register file
// read is registered at accept and the ALU plus write-back run as s1 advances into rsp.
// Reset (synchronous): empties the pipeline and marks every register as zero.

module r_type_alu_executor (
   input logic         clock,
   input logic         reset,
   rtaex_req_if.sink   req_chan,
   rtaex_rsp_if.source rsp_chan
);

   logic                          req_fire;
   logic [rtaex_pkg::DATA_W-1:0]  word;

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic                            s1_mode_ff;
   logic                            s1_opc_ok_ff;
   logic [rtaex_pkg::REG_IDX_W-1:0] s1_rd_ff;
   logic [rtaex_pkg::SHAMT_W-1:0]   s1_shamt_ff;
   logic [rtaex_pkg::FUNCT_W-1:0]   s1_funct_ff;
   logic [rtaex_pkg::REG_IDX_W-1:0] s1_load_index_ff;
   logic [rtaex_pkg::DATA_W-1:0]    s1_load_value_ff;
   logic                            s1_adv;

   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic                            out_free;
   logic [rtaex_pkg::REG_IDX_W-1:0] out_index_ff;
   logic [rtaex_pkg::REG_IDX_W-1:0] out_index_in;
   logic [rtaex_pkg::DATA_W-1:0]    out_value_ff;
   logic [rtaex_pkg::DATA_W-1:0]    out_value_in;
   logic                            out_wrote_ff;
   logic                            out_wrote_in;
   logic                            out_status_ff;
   logic                            out_status_in;

   logic [rtaex_pkg::DATA_W-1:0] op_a;
   logic [rtaex_pkg::DATA_W-1:0] op_b;
   logic [rtaex_pkg::DATA_W-1:0] alu_result;
   logic                         alu_supported;
   rtaex_pkg::rf_write_type      rf_wr;

   // Memory image is little-endian; fields are decoded from the big-endian word.
   assign word = {req_chan.instruction_word[7:0],   req_chan.instruction_word[15:8],
                  req_chan.instruction_word[23:16], req_chan.instruction_word[31:24]};

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_free);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff       <= req_chan.mode;
         s1_opc_ok_ff     <= (word[31:26] == rtaex_pkg::OPC_SPECIAL);
         s1_rd_ff         <= word[15:11];
         s1_shamt_ff      <= word[10:6];
         s1_funct_ff      <= word[5:0];
         s1_load_index_ff <= req_chan.load_index;
         s1_load_value_ff <= req_chan.load_value;
      end
      if (s1_adv) begin
         out_index_ff  <= out_index_in;
         out_value_ff  <= out_value_in;
         out_wrote_ff  <= out_wrote_in;
         out_status_ff <= out_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   rtaex_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (word[25:21]),
      .rd_addr_b (word[20:16]),
      .wr        (rf_wr),
      .op_a      (op_a),
      .op_b      (op_b)
   );

   rtaex_alu u_alu (
      .funct     (s1_funct_ff),
      .shamt     (s1_shamt_ff),
      .op_a      (op_a),
      .op_b      (op_b),
      .result    (alu_result),
      .supported (alu_supported)
   );

   always_comb begin
      out_index_in  = '0;
      out_value_in  = '0;
      out_wrote_in  = 1'b0;
      out_status_in = 1'b0;
      if (s1_mode_ff) begin
         if (s1_load_index_ff != '0) begin
            out_index_in = s1_load_index_ff;
            out_value_in = s1_load_value_ff;
            out_wrote_in = 1'b1;
         end
      end else if (!s1_opc_ok_ff || !alu_supported) begin
         out_status_in = 1'b1;
      end else if (s1_rd_ff != '0) begin
         out_index_in = s1_rd_ff;
         out_value_in = alu_result;
         out_wrote_in = 1'b1;
      end
   end

   assign rf_wr.en   = s1_adv && out_wrote_in;
   assign rf_wr.addr = out_index_in;
   assign rf_wr.data = out_value_in;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.dest_index = out_index_ff;
   assign rsp_chan.dest_value = out_value_ff;
   assign rsp_chan.wrote      = out_wrote_ff;
   assign rsp_chan.status     = out_status_ff;

endmodule

// ===== rtl/core/rtaex_alu.sv =====
`timescale 1ns / 1ps

module rtaex_alu (
   input  logic [rtaex_pkg::FUNCT_W-1:0] funct,
   input  logic [rtaex_pkg::SHAMT_W-1:0] shamt,
   input  logic [rtaex_pkg::DATA_W-1:0]  op_a,
   input  logic [rtaex_pkg::DATA_W-1:0]  op_b,
   output logic [rtaex_pkg::DATA_W-1:0]  result,
   output logic                          supported
);

   logic signed [rtaex_pkg::DATA_W-1:0] a_s;
   logic signed [rtaex_pkg::DATA_W-1:0] b_s;

   assign a_s = op_a;
   assign b_s = op_b;

   always_comb begin
      result    = '0;
      supported = 1'b1;
      unique case (funct)
         rtaex_pkg::FN_SLL: result = op_b << shamt;
         rtaex_pkg::FN_SRL: result = op_b >> shamt;
         rtaex_pkg::FN_SRA: result = b_s >>> shamt;
         rtaex_pkg::FN_ADD: result = op_a + op_b;
         rtaex_pkg::FN_SUB: result = op_a - op_b;
         rtaex_pkg::FN_AND: result = op_a & op_b;
         rtaex_pkg::FN_OR:  result = op_a | op_b;
         rtaex_pkg::FN_XOR: result = op_a ^ op_b;
         rtaex_pkg::FN_NOR: result = ~(op_a | op_b);
         rtaex_pkg::FN_SLT: result = {{(rtaex_pkg::DATA_W-1){1'b0}}, (a_s < b_s)};
         default:           supported = 1'b0;
      endcase
   end

endmodule

// ===== rtl/core/rtaex_regfile.sv =====
`timescale 1ns / 1ps

module rtaex_regfile (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [rtaex_pkg::REG_IDX_W-1:0] rd_addr_a,
   input  logic [rtaex_pkg::REG_IDX_W-1:0] rd_addr_b,
   input  rtaex_pkg::rf_write_type         wr,
   output logic [rtaex_pkg::DATA_W-1:0]    op_a,
   output logic [rtaex_pkg::DATA_W-1:0]    op_b
);

   logic [rtaex_pkg::DATA_W-1:0]    mem_ff [rtaex_pkg::REG_COUNT];
   logic [rtaex_pkg::DATA_W-1:0]    rdata_a_ff;
   logic [rtaex_pkg::DATA_W-1:0]    rdata_b_ff;
   logic [rtaex_pkg::REG_IDX_W-1:0] addr_a_ff;
   logic [rtaex_pkg::REG_IDX_W-1:0] addr_b_ff;

   logic [rtaex_pkg::REG_COUNT-1:0] valid_ff;
   logic [rtaex_pkg::REG_COUNT-1:0] valid_in;

   // Most recent write, for the read that shares its edge.
   logic                            fwd_en_ff;
   logic [rtaex_pkg::REG_IDX_W-1:0] fwd_addr_ff;
   logic [rtaex_pkg::DATA_W-1:0]    fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_a_ff <= mem_ff[rd_addr_a];
         rdata_b_ff <= mem_ff[rd_addr_b];
         addr_a_ff  <= rd_addr_a;
         addr_b_ff  <= rd_addr_b;
      end
      if (wr.en) begin
         fwd_addr_ff <= wr.addr;
         fwd_data_ff <= wr.data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         fwd_en_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         fwd_en_ff <= fwd_en_ff | wr.en;
      end
   end

   // Entry 0 is hardwired to zero; entries never written since reset read as zero.
   always_comb begin
      if (addr_a_ff == '0) begin
         op_a = '0;
      end else if (fwd_en_ff && fwd_addr_ff == addr_a_ff) begin
         op_a = fwd_data_ff;
      end else if (valid_ff[addr_a_ff]) begin
         op_a = rdata_a_ff;
      end else begin
         op_a = '0;
      end

      if (addr_b_ff == '0) begin
         op_b = '0;
      end else if (fwd_en_ff && fwd_addr_ff == addr_b_ff) begin
         op_b = fwd_data_ff;
      end else if (valid_ff[addr_b_ff]) begin
         op_b = rdata_b_ff;
      end else begin
         op_b = '0;
      end
   end

endmodule

// ===== rtl/core/rtaex_checker.sv =====
`timescale 1ns / 1ps
`include "r_type_alu_executor_defines.svh"

module rtaex_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rtaex_pkg::REG_IDX_W-1:0] rsp_dest_index,
   input logic [rtaex_pkg::DATA_W-1:0]    rsp_dest_value,
   input logic                            rsp_wrote,
   input logic                            rsp_status
);

   `RTAEX_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped while stalled")
   `RTAEX_ASSERT(a_wrote_ok, rsp_valid && rsp_wrote |-> !rsp_status && rsp_dest_index != '0, "write reported with error or to register zero")
   `RTAEX_ASSERT(a_nowrite_zero, rsp_valid && !rsp_wrote |-> rsp_dest_index == '0 && rsp_dest_value == '0, "no-write transaction carries a nonzero destination")
   `RTAEX_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid, "rsp valid right after reset")

endmodule

bind r_type_alu_executor rtaex_checker u_rtaex_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_dest_index (rsp_chan.dest_index),
   .rsp_dest_value (rsp_chan.dest_value),
   .rsp_wrote      (rsp_chan.wrote),
   .rsp_status     (rsp_chan.status)
);
